/* hdl/aes_cmac_tag_engine_macros.svh */
// assertion macros shared by the cmac tag engine
`ifndef AES_CMAC_TAG_ENGINE_MACROS_SVH
`define AES_CMAC_TAG_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ACMAC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acmac check failed");

// next-cycle implication, checked outside reset
`define ACMAC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acmac check failed");

`endif

/* hdl/acmac_pkg.sv */
// shared types, constants and functions of the cmac tag engine
package acmac_pkg;

  localparam int TAG_BYTES = 8;
  localparam int ROUNDS    = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(1);

  localparam logic [7:0] GF8_POLY   = 8'h1b;
  localparam logic [7:0] GF128_POLY = 8'h87;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  // leading tag bytes kept, the rest forced to zero
  localparam logic [63:0] TAG_MASK = (TAG_BYTES >= 8) ? {64{1'b1}} :
                                     ~({64{1'b1}} >> (8 * TAG_BYTES));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYS,
    ST_LAUNCH,
    ST_MSG
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } aes_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? GF8_POLY : 8'h00);
  endfunction

  function automatic logic [127:0] gf128_dbl(input logic [127:0] x);
    gf128_dbl = {x[126:0], 1'b0} ^ {120'd0, (x[127] ? GF128_POLY : 8'h00)};
  endfunction

endpackage

/* hdl/acmac_if.sv */
// handshake channels: message blocks, tags and key writes
interface acmac_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic [4:0]  byte_count;
  logic        last_block;
  modport source (output valid, block_high, block_low, byte_count, last_block, input ready);
  modport sink   (input valid, block_high, block_low, byte_count, last_block, output ready);
endinterface

interface acmac_tag_if;
  logic        valid;
  logic        ready;
  logic [63:0] mac_tag;
  modport source (output valid, mac_tag, input ready);
  modport sink   (input valid, mac_tag, output ready);
endinterface

interface acmac_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/acmac_round.sv */
// one aes-128 round with the matching key expansion step
module acmac_round (
  input  logic [127:0] state_in,
  input  logic [127:0] rkey_in,
  input  logic [7:0]   rcon,
  input  logic         final_round,
  output logic [127:0] state_out,
  output logic [127:0] rkey_out
);
  import acmac_pkg::*;

  logic [31:0] kw;
  logic [31:0] w0, w1, w2, w3;
  logic [7:0]  sb [16];
  logic [7:0]  t  [16];
  logic [7:0]  m  [16];
  logic [127:0] mixed;

  // key schedule: rotword, subword, rcon
  always_comb begin
    kw = {SBOX[rkey_in[23:16]] ^ rcon, SBOX[rkey_in[15:8]],
          SBOX[rkey_in[7:0]], SBOX[rkey_in[31:24]]};
    w0 = rkey_in[127:96] ^ kw;
    w1 = rkey_in[95:64] ^ w0;
    w2 = rkey_in[63:32] ^ w1;
    w3 = rkey_in[31:0] ^ w2;
    rkey_out = {w0, w1, w2, w3};
  end

  // subbytes, shiftrows, mixcolumns (skipped in the final round), then round key addition
  always_comb begin
    logic [7:0] a0, a1, a2, a3, al;
    for (int i = 0; i < 16; i++) begin
      sb[i] = state_in[127 - 8 * i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c * 4 + r] = SBOX[sb[((c + r) & 3) * 4 + r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[c * 4];
      a1 = t[c * 4 + 1];
      a2 = t[c * 4 + 2];
      a3 = t[c * 4 + 3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (final_round) begin
        m[c * 4]     = a0;
        m[c * 4 + 1] = a1;
        m[c * 4 + 2] = a2;
        m[c * 4 + 3] = a3;
      end else begin
        m[c * 4]     = a0 ^ al ^ xtime(a0 ^ a1);
        m[c * 4 + 1] = a1 ^ al ^ xtime(a1 ^ a2);
        m[c * 4 + 2] = a2 ^ al ^ xtime(a2 ^ a3);
        m[c * 4 + 3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      mixed[127 - 8 * i -: 8] = m[i];
    end
    state_out = mixed ^ rkey_out;
  end
endmodule

/* hdl/acmac_aes.sv */
// iterative aes-128 encryptor, one round per cycle through a shared round unit
module acmac_aes (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [127:0]         key,
  input  logic [127:0]         din,
  output acmac_pkg::aes_stat_t stat,
  output logic [127:0]         dout
);
  import acmac_pkg::*;

  logic [127:0] st;
  logic [127:0] rk;
  logic [7:0]   rc;
  logic [3:0]   rnd;
  logic         busy;
  logic         done;
  logic [127:0] st_next;
  logic [127:0] rk_next;
  logic         final_round;

  assign final_round = (rnd == 4'(ROUNDS));

  acmac_round u_round (
    .state_in    (st),
    .rkey_in     (rk),
    .rcon        (rc),
    .final_round (final_round),
    .state_out   (st_next),
    .rkey_out    (rk_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && final_round;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && final_round) begin
        busy <= 1'b0;
      end
    end
  end

  // initial key whitening on start, then one round a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      st  <= din ^ key;
      rk  <= key;
      rc  <= 8'h01;
      rnd <= 4'd1;
    end else if (busy) begin
      st  <= st_next;
      rk  <= rk_next;
      rc  <= xtime(rc);
      rnd <= rnd + 4'd1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign dout      = st;
endmodule

/* hdl/aes_cmac_tag_engine.sv */
// aes-128 cmac tag engine: sequencer, key and subkey registers, chaining and tag output
//
//  channel | dir | payload                                       | role
//  --------+-----+-----------------------------------------------+--------------------------
//  blk     | in  | block_high, block_low, byte_count, last_block | one 16-byte message block
//  tag     | out | mac_tag                                       | leading tag bytes
//  cfg     | in  | index, data                                   | key register writes
//
//  between the accept of a block request and the next accept the sequencer loads the aes
//  unit, runs the ten rounds through the single shared round unit and takes the result; the
//  first block after reset or a key write first encrypts the zero block and derives the
//  subkeys
//  rst is synchronous and clears the key, chaining value, subkeys and control state
//  blk.ready is low while a block is in flight or a tag still waits on tag.ready
//  cfg is always ready; key writes land at once and force a fresh subkey derivation
module aes_cmac_tag_engine (
  input logic        clk,
  input logic        rst,
  acmac_blk_if.sink  blk,
  acmac_tag_if.source tag,
  acmac_cfg_if.sink  cfg
);
  import acmac_pkg::*;

  seq_state_t   state, state_next;
  aes_stat_t    aes_st;
  logic [127:0] aes_dout;
  logic [127:0] aes_din;
  logic         aes_start;

  logic [63:0]  key_high, key_low;
  logic [127:0] chain_value;
  logic [127:0] subkey_one, subkey_two;
  logic         subkeys_ready;

  // captured request
  logic [127:0] msg;
  logic [4:0]   cnt;
  logic         last;

  logic [63:0]  tag_data;
  logic         tag_valid;

  logic         blk_acc;
  logic [127:0] padded;
  logic [127:0] prepared;

  assign blk_acc   = blk.valid && blk.ready;
  assign blk.ready = (state == ST_IDLE) && !tag_valid;
  assign cfg.ready = 1'b1;

  assign tag.valid   = tag_valid;
  assign tag.mac_tag = tag_data;

  // final-block padding: data bytes, then the pad marker, then zeros
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < cnt) begin
        padded[127 - 8 * i -: 8] = msg[127 - 8 * i -: 8];
      end else if (5'(i) == cnt) begin
        padded[127 - 8 * i -: 8] = PAD_BYTE;
      end else begin
        padded[127 - 8 * i -: 8] = 8'h00;
      end
    end
  end

  // full final block takes k1, short one takes k2; other blocks go in as they are
  always_comb begin
    priority if (!last) begin
      prepared = msg;
    end else if (cnt[4]) begin
      prepared = msg ^ subkey_one;
    end else begin
      prepared = padded ^ subkey_two;
    end
  end

  acmac_aes u_aes (
    .clk   (clk),
    .rst   (rst),
    .start (aes_start),
    .key   ({key_high, key_low}),
    .din   (aes_din),
    .stat  (aes_st),
    .dout  (aes_dout)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (blk_acc) begin
          state_next = subkeys_ready ? ST_LAUNCH : ST_KEYS;
        end
      end
      ST_KEYS: begin
        if (aes_st.done) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: state_next = ST_MSG;
      ST_MSG: begin
        if (aes_st.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: aes launch and its input
  always_comb begin
    aes_start = 1'b0;
    aes_din   = chain_value ^ prepared;
    unique case (state)
      ST_IDLE: begin
        if (blk_acc && !subkeys_ready) begin
          aes_start = 1'b1;
          aes_din   = '0;
        end
      end
      ST_LAUNCH: aes_start = 1'b1;
      ST_KEYS, ST_MSG: aes_start = 1'b0;
      default: aes_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // key registers and subkey validity
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high      <= '0;
      key_low       <= '0;
      subkeys_ready <= 1'b0;
      subkey_one    <= '0;
      subkey_two    <= '0;
    end else begin
      if (state == ST_KEYS && aes_st.done) begin
        subkey_one    <= gf128_dbl(aes_dout);
        subkey_two    <= gf128_dbl(gf128_dbl(aes_dout));
        subkeys_ready <= 1'b1;
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_KEY_HIGH) begin
          key_high      <= cfg.data;
          subkeys_ready <= 1'b0;
        end else if (cfg.index == REG_KEY_LOW) begin
          key_low       <= cfg.data;
          subkeys_ready <= 1'b0;
        end
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (blk_acc) begin
      msg  <= {blk.block_high, blk.block_low};
      cnt  <= blk.byte_count;
      last <= blk.last_block;
    end
  end

  // chaining value and tag register
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_value <= '0;
      tag_valid   <= 1'b0;
    end else begin
      if (tag_valid && tag.ready) begin
        tag_valid <= 1'b0;
      end
      if (state == ST_MSG && aes_st.done) begin
        if (last) begin
          chain_value <= '0;
          tag_valid   <= 1'b1;
        end else begin
          chain_value <= aes_dout;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MSG && aes_st.done && last) begin
      tag_data <= aes_dout[127:64] & TAG_MASK;
    end
  end

  `include "aes_cmac_tag_engine_macros.svh"

  // a finished final block always raises the tag
  `ACMAC_ASSERT_NEXT(a_tag_on_final, state == ST_MSG && aes_st.done && last, tag_valid)
  // the subkey pass ends with subkeys marked ready unless a key write lands
  `ACMAC_ASSERT_NEXT(a_keys_ready, state == ST_KEYS && aes_st.done && !cfg.valid, subkeys_ready)
  // the aes unit only runs while the sequencer owns it
  `ACMAC_ASSERT_NOW(a_aes_owned, aes_st.busy, state == ST_KEYS || state == ST_MSG)
  // end of message resets the chain
  `ACMAC_ASSERT_NEXT(a_chain_clear, state == ST_MSG && aes_st.done && last, chain_value == '0)
endmodule
